// ----- design/pawq_pkg.sv -----
`timescale 1ns / 1ps
// Package for the pause-aware egress queue: codes, field widths, the descriptor
// and result layouts, and the controller/datapath command and status types.
// Used by every module of the block; depends on nothing.
package pawq_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;

    localparam int SIZE_W   = 14;
    localparam int SRC_W    = 8;
    localparam int PTIME_W  = 16;
    localparam int QBYTES_W = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 64;

    // Event kinds carried in the input tuser.
    localparam logic [1:0] KIND_ARRIVE   = 2'd0;
    localparam logic [1:0] KIND_PAUSE    = 2'd1;
    localparam logic [1:0] KIND_COMPLETE = 2'd2;

    // Port send states.
    localparam logic [1:0] SEND_READY   = 2'd0;
    localparam logic [1:0] SEND_PENDING = 2'd1;
    localparam logic [1:0] SEND_PAUSED  = 2'd2;

    // Error codes.
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_STRAY  = 2'd1;
    localparam logic [1:0] ERR_FULL   = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ECN_ENABLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ECN_THRESH = 2'd2;

    typedef struct packed {
        logic               ecn;
        logic [SRC_W-1:0]   src;
        logic [SIZE_W-1:0]  size;
    } t_desc;

    // Result beat, lowest field in the lowest bits.
    typedef struct packed {
        logic [1:0]          error_code;
        logic                over_limit;
        logic [1:0]          send_state;
        logic [QBYTES_W-1:0] queue_bytes;
        logic [SIZE_W-1:0]   start_size;
        logic                start_tx;
        logic                depart_ecn;
        logic [SRC_W-1:0]    depart_source;
        logic [SIZE_W-1:0]   depart_size;
        logic                depart_valid;
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD_HEAD,
        ST_RD_START,
        ST_COMMIT
    } t_state;

    typedef struct packed {
        logic accept;     // latch the input beat
        logic rd_head;    // read the descriptor at the head, write an arrival
        logic rd_start;   // capture the head, read the descriptor to start
        logic commit;     // update queue state and load the result register
    } t_cmd;

    typedef struct packed {
        logic out_free;   // result register can take a new beat this cycle
    } t_status;

endpackage

// ----- design/pause_aware_egress_queue.sv -----
`timescale 1ns / 1ps
// Top level of the pause-aware egress queue: joins the controller and the
// datapath and ties off the configuration handshake. Depends on pawq_pkg,
// pawq_ctrl and pawq_datapath.
//
//  Channel   Direction  Signals                          Beat
//  s_        in         i_s_tvalid/o_s_tready            one event per beat
//  m_        out        o_m_tvalid/i_m_tready            one result per event
//  cfg       in         i_cfg_valid/o_cfg_ready          one register write
//
// Each event passes through four steps: accept, head read, start read, commit;
// the descriptor memory, read at one address per cycle and twice per event,
// sets the two read steps.
// A result waits in the output register while the next event is accepted;
// the commit of that next event stalls until the waiting beat is taken.
// Reset is synchronous and active low; the queue comes out of it empty and
// ready to send, with no clearing pass. Configuration writes are always taken.
module pause_aware_egress_queue
    import pawq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // pkt_size[13:0], source_queue[21:14], ecn_in[22], pause_time[38:23], zero[39]
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // kind[1:0]
    input  logic [1:0]            i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // depart_valid[0], depart_size[14:1], depart_source[22:15], depart_ecn[23],
    // start_tx[24], start_size[38:25], queue_bytes[58:39], send_state[60:59],
    // over_limit[61], error_code[63:62]
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    pawq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_status   (status),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd)
    );

    pawq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata)
    );

endmodule

// ----- design/pawq_ctrl.sv -----
`timescale 1ns / 1ps
// Controller of the pause-aware egress queue: sequences each event through
// accept, two descriptor reads and a commit. Depends on pawq_pkg.
module pawq_ctrl
    import pawq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    input  t_status i_status,
    output logic    o_s_tready,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) n_state = ST_RD_HEAD;
            end
            ST_RD_HEAD:  n_state = ST_RD_START;
            ST_RD_START: n_state = ST_COMMIT;
            ST_COMMIT: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready   = 1'b1;
                o_cmd.accept = i_s_tvalid;
            end
            ST_RD_HEAD:  o_cmd.rd_head  = 1'b1;
            ST_RD_START: o_cmd.rd_start = 1'b1;
            ST_COMMIT:   o_cmd.commit   = i_status.out_free;
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ----- design/pawq_datapath.sv -----
`timescale 1ns / 1ps
// Datapath of the pause-aware egress queue: descriptor memory, pointers, byte
// count, pause state, configuration registers and the result register.
// Depends on pawq_pkg; driven by commands from pawq_ctrl.
module pawq_datapath
    import pawq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic [1:0]            i_s_tuser,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_m_tready,
    output logic                  o_m_tvalid,
    output logic [OUT_DATA_W-1:0] o_m_tdata
);

    localparam int PW     = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW     = $clog2(QUEUE_DEPTH + 1);
    localparam int BW_RAW = $clog2(QUEUE_DEPTH * (2 ** SIZE_W));
    localparam int BW     = (BW_RAW > QBYTES_W + 1) ? BW_RAW : QBYTES_W + 1;
    localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(QUEUE_DEPTH);

    function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
        next_slot = (p == LAST_SLOT) ? '0 : p + PW'(1);
    endfunction

    t_desc mem [QUEUE_DEPTH];

    // Latched input beat.
    logic [1:0]          r_kind;
    t_desc               r_in;
    logic [PTIME_W-1:0]  r_ptime;

    logic [PW-1:0]       r_head, n_head;
    logic [PW-1:0]       r_tail, n_tail;
    logic [CW-1:0]       r_count, n_count;
    logic [BW-1:0]       r_bytes, n_bytes;
    logic [1:0]          r_pause, n_pause;
    logic                r_flight, n_flight;

    logic [QBYTES_W-1:0] r_byte_limit;
    logic                r_ecn_enable;
    logic [QBYTES_W-1:0] r_ecn_thresh;

    t_desc               r_rd_data;
    t_desc               r_dep;
    t_result             r_out, n_out;
    logic                r_out_valid;

    logic [PW-1:0]       rd_addr;
    logic                wr_en;
    logic [BW-1:0]       dep_size;

    assign o_status.out_free = !r_out_valid || i_m_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind  <= i_s_tuser;
            r_in    <= i_s_tdata[SIZE_W+SRC_W:0];
            r_ptime <= i_s_tdata[SIZE_W+SRC_W+PTIME_W:SIZE_W+SRC_W+1];
        end
    end

    // The write of an arrival lands before the start read of the next cycle,
    // so an arrival into an empty store starts from its own descriptor.
    assign wr_en   = i_cmd.rd_head && (r_kind == KIND_ARRIVE) && (r_count < FULL_CNT);
    assign rd_addr = i_cmd.rd_head ? r_head :
                     ((r_kind == KIND_COMPLETE) ? next_slot(r_head) : r_head);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_tail] <= r_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_head || i_cmd.rd_start) begin
            r_rd_data <= mem[rd_addr];
        end
        if (i_cmd.rd_start) begin
            r_dep <= r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_limit <= '1;
            r_ecn_enable <= 1'b0;
            r_ecn_thresh <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BYTE_LIMIT: r_byte_limit <= i_cfg_data;
                CFG_ECN_ENABLE: r_ecn_enable <= i_cfg_data[0];
                CFG_ECN_THRESH: r_ecn_thresh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign dep_size = BW'(r_dep.size);

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_bytes  = r_bytes;
        n_pause  = r_pause;
        n_flight = r_flight;
        n_out    = '0;
        case (r_kind)
            KIND_ARRIVE: begin
                if (r_count >= FULL_CNT) begin
                    n_out.error_code = ERR_FULL;
                end else begin
                    n_tail  = next_slot(r_tail);
                    n_count = r_count + CW'(1);
                    n_bytes = r_bytes + BW'(r_in.size);
                    n_out.over_limit = (n_bytes > BW'(r_byte_limit));
                    if (r_pause == SEND_READY && !r_flight) begin
                        n_out.start_tx   = 1'b1;
                        n_out.start_size = r_rd_data.size;
                        n_flight         = 1'b1;
                    end
                end
            end
            KIND_PAUSE: begin
                if (r_ptime != '0) begin
                    n_pause = r_flight ? SEND_PENDING : SEND_PAUSED;
                end else begin
                    n_pause = SEND_READY;
                    if (r_count != '0 && !r_flight) begin
                        n_out.start_tx   = 1'b1;
                        n_out.start_size = r_rd_data.size;
                        n_flight         = 1'b1;
                    end
                end
            end
            KIND_COMPLETE: begin
                if (!r_flight || r_count == '0) begin
                    n_out.error_code = ERR_STRAY;
                end else begin
                    n_head  = next_slot(r_head);
                    n_count = r_count - CW'(1);
                    n_out.depart_valid  = 1'b1;
                    n_out.depart_size   = r_dep.size;
                    n_out.depart_source = r_dep.src;
                    // Marking looks at the byte count before the packet leaves.
                    n_out.depart_ecn    = r_dep.ecn ||
                                          (r_ecn_enable && (r_bytes > BW'(r_ecn_thresh)));
                    n_bytes  = (r_bytes >= dep_size) ? r_bytes - dep_size : '0;
                    n_flight = 1'b0;
                    if (r_pause == SEND_PENDING) n_pause = SEND_PAUSED;
                    if (n_count != '0 && n_pause == SEND_READY) begin
                        n_out.start_tx   = 1'b1;
                        n_out.start_size = r_rd_data.size;
                        n_flight         = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        n_out.queue_bytes = (n_bytes > BW'({QBYTES_W{1'b1}})) ? '1 : n_bytes[QBYTES_W-1:0];
        n_out.send_state  = n_pause;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_bytes     <= '0;
            r_pause     <= SEND_READY;
            r_flight    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_head   <= n_head;
                r_tail   <= n_tail;
                r_count  <= n_count;
                r_bytes  <= n_bytes;
                r_pause  <= n_pause;
                r_flight <= n_flight;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

endmodule
